// ===== rtl/core/stripe_sector_mapper_core_assert.svh =====
// assertion macros for the stripe sector mapper checker
// no dependencies; expects clock and reset in the using scope
`ifndef STRIPE_SECTOR_MAPPER_CORE_ASSERT_SVH
`define STRIPE_SECTOR_MAPPER_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define SSM_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SSM_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ssm_pkg.sv =====
// shared types and constants for the stripe sector mapper
// no dependencies
package ssm_pkg;

   localparam int CHUNK_W = 32;
   localparam int DEV_W   = 5;
   localparam int BASE_W  = 48;
   localparam int CSR_W   = 48;
   localparam int IDX_W   = 2;

   typedef enum logic [IDX_W-1:0] {
      CSR_CHUNK_SECTORS = 2'd0,
      CSR_STRIPE_COUNT  = 2'd1,
      CSR_TARGET_BASE   = 2'd2
   } ssm_csr_type;

   typedef struct packed {
      logic       op;
      logic [3:0] tgt;
   } ssm_ctl_type;

   typedef struct packed {
      ssm_ctl_type        ctl;
      logic [CHUNK_W-1:0] within_a;
      logic [CHUNK_W-1:0] within_b;
   } ssm_row_tag_type;

endpackage

// ===== rtl/core/ssm_divpipe.sv =====
// two-lane pipelined restoring divider, one quotient bit per stage
// depends on nothing; user must hold the shared divisor steady while items are in flight (not enforced)
module ssm_divpipe #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 32,
   parameter int TAG_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num_a,
   input  logic [NUM_W-1:0] in_num_b,
   input  logic [TAG_W-1:0] in_tag,
   input  logic [DEN_W-1:0] den,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo_a,
   output logic [NUM_W-1:0] out_quo_b,
   output logic [DEN_W-1:0] out_rem_a,
   output logic [DEN_W-1:0] out_rem_b,
   output logic [TAG_W-1:0] out_tag
);

   logic             valid_ff [NUM_W];
   logic [TAG_W-1:0] tag_ff   [NUM_W];
   logic [NUM_W-1:0] num_ff   [2][NUM_W];
   logic [DEN_W-1:0] rem_ff   [2][NUM_W];

   genvar s, l;
   generate
      for (s = 0; s < NUM_W; s++) begin : g_stage
         logic             valid_prev;
         logic [TAG_W-1:0] tag_prev;
         if (s == 0) begin : g_first
            assign valid_prev = in_valid;
            assign tag_prev   = in_tag;
         end else begin : g_next
            assign valid_prev = valid_ff[s-1];
            assign tag_prev   = tag_ff[s-1];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else begin
               valid_ff[s] <= valid_prev;
            end
         end

         always_ff @(posedge clock) begin
            tag_ff[s] <= tag_prev;
         end

         for (l = 0; l < 2; l++) begin : g_lane
            logic [NUM_W-1:0] num_prev;
            logic [DEN_W-1:0] rem_prev;
            logic [DEN_W:0]   trial;
            logic             ge;
            logic [DEN_W-1:0] rem_in;
            logic [NUM_W-1:0] num_in;
            if (s == 0) begin : g_first
               assign num_prev = (l == 0) ? in_num_a : in_num_b;
               assign rem_prev = '0;
            end else begin : g_next
               assign num_prev = num_ff[l][s-1];
               assign rem_prev = rem_ff[l][s-1];
            end

            always_comb begin
               trial  = {rem_prev, num_prev[NUM_W-1]};
               ge     = trial >= {1'b0, den};
               rem_in = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
               num_in = {num_prev[NUM_W-2:0], ge};
            end

            always_ff @(posedge clock) begin
               num_ff[l][s] <= num_in;
               rem_ff[l][s] <= rem_in;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[NUM_W-1];
   assign out_tag   = tag_ff[NUM_W-1];
   assign out_quo_a = num_ff[0][NUM_W-1];
   assign out_quo_b = num_ff[1][NUM_W-1];
   assign out_rem_a = rem_ff[0][NUM_W-1];
   assign out_rem_b = rem_ff[1][NUM_W-1];

endmodule

// ===== rtl/core/ssm_scale.sv =====
// back end: row times chunk size, edge rounding, range length and result register
// depends on ssm_pkg
module ssm_scale #(
   parameter int SB = 48
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  ssm_pkg::ssm_row_tag_type in_tag,
   input  logic [SB-1:0]           row_a,
   input  logic [SB-1:0]           row_b,
   input  logic [ssm_pkg::DEV_W-1:0] dev_a,
   input  logic [ssm_pkg::DEV_W-1:0] dev_b,
   input  logic [ssm_pkg::CHUNK_W-1:0] chunk,
   input  logic [ssm_pkg::DEV_W-1:0] stripes,
   output logic                    rsp_valid,
   output logic [3:0]              rsp_stripe_index,
   output logic [SB-1:0]           rsp_device_sector,
   output logic [SB-1:0]           rsp_range_length,
   output logic                    rsp_range_hit
);
   import ssm_pkg::*;

   localparam int H = SB / 2;
   localparam int L = SB - H;

   // stage 1: split products
   logic                v1_ff;
   ssm_row_tag_type     tag1_ff;
   logic [DEV_W-1:0]    dev_a1_ff, dev_b1_ff;
   logic [H+CHUNK_W-1:0] plo_a_ff, plo_b_ff;
   logic [L-1:0]        phi_a_ff, phi_b_ff;
   logic [L+CHUNK_W-1:0] phi_a_in, phi_b_in;

   assign phi_a_in = row_a[SB-1:H] * chunk;
   assign phi_b_in = row_b[SB-1:H] * chunk;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      tag1_ff   <= in_tag;
      dev_a1_ff <= dev_a;
      dev_b1_ff <= dev_b;
      plo_a_ff  <= row_a[H-1:0] * chunk;
      plo_b_ff  <= row_b[H-1:0] * chunk;
      phi_a_ff  <= phi_a_in[L-1:0];
      phi_b_ff  <= phi_b_in[L-1:0];
   end

   // stage 2: combine partial products into row * chunk
   logic             v2_ff;
   ssm_row_tag_type  tag2_ff;
   logic [DEV_W-1:0] dev_a2_ff, dev_b2_ff;
   logic [SB-1:0]    base_a_ff, base_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      tag2_ff   <= tag1_ff;
      dev_a2_ff <= dev_a1_ff;
      dev_b2_ff <= dev_b1_ff;
      base_a_ff <= SB'(plo_a_ff) + {phi_a_ff, {H{1'b0}}};
      base_b_ff <= SB'(plo_b_ff) + {phi_b_ff, {H{1'b0}}};
   end

   // stage 3: device sector and rounded range edges
   logic             v3_ff;
   ssm_ctl_type      ctl3_ff;
   logic [DEV_W-1:0] dev3_ff;
   logic [SB-1:0]    dsec3_ff, beg3_ff, end3_ff;
   logic [SB-1:0]    dsec_a_in, dsec_b_in, beg_in, end_in;
   logic [SB:0]      step_a, step_b;
   logic [DEV_W-1:0] tgt_ext;

   always_comb begin
      tgt_ext   = DEV_W'(tag2_ff.ctl.tgt);
      dsec_a_in = base_a_ff + SB'(tag2_ff.within_a);
      dsec_b_in = base_b_ff + SB'(tag2_ff.within_b);
      step_a    = {1'b0, base_a_ff} + (SB+1)'(chunk);
      step_b    = {1'b0, base_b_ff} + (SB+1)'(chunk);
      if (tgt_ext == dev_a2_ff) begin
         beg_in = dsec_a_in;
      end else if (tgt_ext < dev_a2_ff) begin
         beg_in = step_a[SB] ? {SB{1'b1}} : step_a[SB-1:0];
      end else begin
         beg_in = base_a_ff;
      end
      if (tgt_ext == dev_b2_ff) begin
         end_in = dsec_b_in;
      end else if (tgt_ext < dev_b2_ff) begin
         end_in = step_b[SB] ? {SB{1'b1}} : step_b[SB-1:0];
      end else begin
         end_in = base_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      ctl3_ff  <= tag2_ff.ctl;
      dev3_ff  <= dev_a2_ff;
      dsec3_ff <= dsec_a_in;
      beg3_ff  <= beg_in;
      end3_ff  <= end_in;
   end

   // stage 4: result register
   logic          valid_ff;
   logic [3:0]    index_ff;
   logic [SB-1:0] sector_ff, length_ff;
   logic          hit_ff;
   logic          hit_in;

   assign hit_in = ctl3_ff.op && (beg3_ff < end3_ff) &&
                   (DEV_W'(ctl3_ff.tgt) < stripes);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      index_ff  <= ctl3_ff.op ? ctl3_ff.tgt : dev3_ff[3:0];
      sector_ff <= ctl3_ff.op ? beg3_ff : dsec3_ff;
      length_ff <= hit_in ? end3_ff - beg3_ff : '0;
      hit_ff    <= hit_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_stripe_index  = index_ff;
   assign rsp_device_sector = sector_ff;
   assign rsp_range_length  = length_ff;
   assign rsp_range_hit     = hit_ff;

endmodule

// ===== rtl/core/stripe_sector_mapper_core.sv =====
// a request is registered at the input, then passes both divider pipelines and the scale back end
// throughput: one request per cycle; busy is high only during reset, the two divider
// pipelines (chunk size, then stripe count) retire one quotient bit per stage
// the result strobe lasts one cycle and cannot be held off
// reset clears all valid bits and loads chunk 8, one stripe, base 0
module stripe_sector_mapper_core #(
   parameter int MAX_STRIPES = 16,
   parameter int SECTOR_BITS = 48
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_operation,
   input  logic [SECTOR_BITS-1:0]       req_sector,
   input  logic [SECTOR_BITS-1:0]       req_end_sector,
   input  logic [3:0]                   req_target_stripe,
   output logic                         rsp_valid,
   output logic [3:0]                   rsp_stripe_index,
   output logic [SECTOR_BITS-1:0]       rsp_device_sector,
   output logic [SECTOR_BITS-1:0]       rsp_range_length,
   output logic                         rsp_range_hit,
   input  logic                         csr_we,
   input  logic [ssm_pkg::IDX_W-1:0]    csr_index,
   input  logic [ssm_pkg::CSR_W-1:0]    csr_wdata
);
   import ssm_pkg::*;

   localparam int SB = SECTOR_BITS;

   logic [CHUNK_W-1:0] chunk_ff;
   logic [DEV_W-1:0]   stripes_ff;
   logic [BASE_W-1:0]  base_ff;
   logic [CHUNK_W-1:0] chunk_eff;
   logic [DEV_W-1:0]   stripes_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff   <= CHUNK_W'(8);
         stripes_ff <= DEV_W'(1);
         base_ff    <= '0;
      end else if (csr_we) begin
         case (ssm_csr_type'(csr_index))
            CSR_CHUNK_SECTORS: chunk_ff   <= csr_wdata[CHUNK_W-1:0];
            CSR_STRIPE_COUNT:  stripes_ff <= csr_wdata[DEV_W-1:0];
            CSR_TARGET_BASE:   base_ff    <= csr_wdata[BASE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      chunk_eff = (chunk_ff == '0) ? CHUNK_W'(1) : chunk_ff;
      if (stripes_ff == '0) begin
         stripes_eff = DEV_W'(1);
      end else if (int'(stripes_ff) > MAX_STRIPES) begin
         stripes_eff = DEV_W'(MAX_STRIPES);
      end else begin
         stripes_eff = stripes_ff;
      end
   end

   // no transfer is taken while reset is held
   assign busy = reset;

   // input stage: offsets into the target, wrapping below the base
   logic          s0_valid_ff;
   ssm_ctl_type   s0_ctl_ff;
   logic [SB-1:0] s0_off_a_ff, s0_off_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      s0_ctl_ff.op  <= req_operation;
      s0_ctl_ff.tgt <= req_target_stripe;
      s0_off_a_ff   <= req_sector - SB'(base_ff);
      s0_off_b_ff   <= req_end_sector - SB'(base_ff);
   end

   // chunk number and offset within chunk
   logic               d1_valid;
   logic [SB-1:0]      d1_chunk_a, d1_chunk_b;
   logic [CHUNK_W-1:0] d1_within_a, d1_within_b;
   ssm_ctl_type        d1_ctl;

   ssm_divpipe #(
      .NUM_W(SB),
      .DEN_W(CHUNK_W),
      .TAG_W($bits(ssm_ctl_type))
   ) u_chunk_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s0_valid_ff),
      .in_num_a (s0_off_a_ff),
      .in_num_b (s0_off_b_ff),
      .in_tag   (s0_ctl_ff),
      .den      (chunk_eff),
      .out_valid(d1_valid),
      .out_quo_a(d1_chunk_a),
      .out_quo_b(d1_chunk_b),
      .out_rem_a(d1_within_a),
      .out_rem_b(d1_within_b),
      .out_tag  (d1_ctl)
   );

   // chunk row and device
   ssm_row_tag_type  d2_tag_in, d2_tag;
   logic             d2_valid;
   logic [SB-1:0]    d2_row_a, d2_row_b;
   logic [DEV_W-1:0] d2_dev_a, d2_dev_b;

   always_comb begin
      d2_tag_in.ctl      = d1_ctl;
      d2_tag_in.within_a = d1_within_a;
      d2_tag_in.within_b = d1_within_b;
   end

   ssm_divpipe #(
      .NUM_W(SB),
      .DEN_W(DEV_W),
      .TAG_W($bits(ssm_row_tag_type))
   ) u_stripe_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (d1_valid),
      .in_num_a (d1_chunk_a),
      .in_num_b (d1_chunk_b),
      .in_tag   (d2_tag_in),
      .den      (stripes_eff),
      .out_valid(d2_valid),
      .out_quo_a(d2_row_a),
      .out_quo_b(d2_row_b),
      .out_rem_a(d2_dev_a),
      .out_rem_b(d2_dev_b),
      .out_tag  (d2_tag)
   );

   ssm_scale #(
      .SB(SB)
   ) u_scale (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (d2_valid),
      .in_tag           (d2_tag),
      .row_a            (d2_row_a),
      .row_b            (d2_row_b),
      .dev_a            (d2_dev_a),
      .dev_b            (d2_dev_b),
      .chunk            (chunk_eff),
      .stripes          (stripes_eff),
      .rsp_valid        (rsp_valid),
      .rsp_stripe_index (rsp_stripe_index),
      .rsp_device_sector(rsp_device_sector),
      .rsp_range_length (rsp_range_length),
      .rsp_range_hit    (rsp_range_hit)
   );

endmodule

// ===== rtl/core/ssm_checker.sv =====
// port-level checker for the stripe sector mapper, bound to the top level
// depends on stripe_sector_mapper_core_assert.svh
`include "stripe_sector_mapper_core_assert.svh"

module ssm_checker #(
   parameter int SB  = 48,
   parameter int LAT = 101
) (
   input logic          clock,
   input logic          reset,
   input logic          start,
   input logic          busy,
   input logic          req_operation,
   input logic [3:0]    req_target_stripe,
   input logic          rsp_valid,
   input logic [3:0]    rsp_stripe_index,
   input logic [SB-1:0] rsp_range_length,
   input logic          rsp_range_hit
);

   `SSM_ASSERT_ALWAYS(a_never_busy, !busy, "pipeline reported busy")
   `SSM_ASSERT_IMPLY(a_strobe_latency, rsp_valid, $past(start, LAT), "result without transfer")
   `SSM_ASSERT_IMPLY(a_miss_no_length, rsp_valid && !rsp_range_hit, rsp_range_length == '0, "length on miss")
   `SSM_ASSERT_IMPLY(a_range_index, rsp_valid && $past(req_operation, LAT), rsp_stripe_index == $past(req_target_stripe, LAT), "range index mismatch")

endmodule

bind stripe_sector_mapper_core ssm_checker #(
   .SB (SECTOR_BITS),
   .LAT(2 * SECTOR_BITS + 5)
) u_ssm_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_operation    (req_operation),
   .req_target_stripe(req_target_stripe),
   .rsp_valid        (rsp_valid),
   .rsp_stripe_index (rsp_stripe_index),
   .rsp_range_length (rsp_range_length),
   .rsp_range_hit    (rsp_range_hit)
);

// ===== tb/stripe_sector_mapper_core_test.sv =====
// testbench for the stripe sector mapper core: single-sector and range mapping
// depends on ssm_pkg and stripe_sector_mapper_core; self-checking against a local predictor
`timescale 1ns / 100ps

module stripe_sector_mapper_core_test;
   import ssm_pkg::*;

   localparam int SB = 48;
   localparam logic [SB-1:0] SEC_MAX = {SB{1'b1}};
   localparam int LATENCY = 2 * SB + 5;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef enum logic {OP_SINGLE = 1'b0, OP_RANGE = 1'b1} map_op_type;

   typedef struct packed {
      logic [3:0]    stripe;
      logic [SB-1:0] dsec;
      logic [SB-1:0] len;
      logic          hit;
   } mapping_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_operation = 1'b0;
   logic [SB-1:0] req_sector = '0;
   logic [SB-1:0] req_end_sector = '0;
   logic [3:0] req_target_stripe = '0;
   logic rsp_valid;
   logic [3:0] rsp_stripe_index;
   logic [SB-1:0] rsp_device_sector;
   logic [SB-1:0] rsp_range_length;
   logic rsp_range_hit;
   logic csr_we = 1'b0;
   logic [IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   // predictor copy of the registers
   logic [31:0] chunk_reg;
   logic [4:0] stripes_reg;
   logic [SB-1:0] base_reg;

   mapping_type expected_maps[$];
   int mismatch_total = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   bit finishing = 1'b0;

   stripe_sector_mapper_core #(.MAX_STRIPES(16), .SECTOR_BITS(SB)) i_dut (.*);

   always #4 clock = ~clock;

   function automatic logic [63:0] eff_chunk();
      return (chunk_reg == 0) ? 64'd1 : {32'd0, chunk_reg};
   endfunction

   function automatic logic [63:0] eff_stripes();
      if (stripes_reg == 0) return 64'd1;
      if (stripes_reg > 16) return 64'd16;
      return {59'd0, stripes_reg};
   endfunction

   function automatic void locate(input logic [SB-1:0] sec, output logic [63:0] dev,
                                  output logic [63:0] dsec);
      logic [63:0] ch, ns, off, chunk;
      ch = eff_chunk();
      ns = eff_stripes();
      off = {16'd0, sec - base_reg};
      chunk = off / ch;
      dev = chunk % ns;
      dsec = ((chunk / ns) * ch + off % ch) & {16'd0, SEC_MAX};
   endfunction

   function automatic logic [63:0] edge_on_device(logic [SB-1:0] sec, logic [3:0] tgt);
      logic [63:0] ch, dev, r;
      ch = eff_chunk();
      locate(sec, dev, r);
      if (dev == tgt) return r;
      r = r - r % ch;
      if (tgt < dev) begin
         if (r > {16'd0, SEC_MAX} - ch) r = {16'd0, SEC_MAX};
         else r = r + ch;
      end
      return r;
   endfunction

   function automatic mapping_type predict_mapping(map_op_type op, logic [SB-1:0] sec,
                                                   logic [SB-1:0] esec, logic [3:0] tgt);
      mapping_type m;
      logic [63:0] dev, dsec, b, e;
      logic hit;
      if (op == OP_SINGLE) begin
         locate(sec, dev, dsec);
         m.stripe = dev[3:0];
         m.dsec = dsec[SB-1:0];
         m.len = '0;
         m.hit = 1'b0;
      end else begin
         b = edge_on_device(sec, tgt);
         e = edge_on_device(esec, tgt);
         hit = (b < e) && ({60'd0, tgt} < eff_stripes());
         m.stripe = tgt;
         m.dsec = b[SB-1:0];
         m.len = hit ? e[SB-1:0] - b[SB-1:0] : '0;
         m.hit = hit;
      end
      return m;
   endfunction

   task automatic report_mismatch(input string what, input logic [SB-1:0] got,
                                  input logic [SB-1:0] want);
      mismatch_total++;
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
   endtask

   // result checker
   always @(posedge clock) begin
      mapping_type want;
      if (!reset && rsp_valid) begin
         if (expected_maps.size() == 0) begin
            report_mismatch("unexpected result transfer", rsp_device_sector, '0);
         end else begin
            want = expected_maps.pop_front();
            if (rsp_stripe_index !== want.stripe)
               report_mismatch("stripe_index", SB'(rsp_stripe_index), SB'(want.stripe));
            if (rsp_device_sector !== want.dsec)
               report_mismatch("device_sector", rsp_device_sector, want.dsec);
            if (rsp_range_length !== want.len)
               report_mismatch("range_length", rsp_range_length, want.len);
            if (rsp_range_hit !== want.hit)
               report_mismatch("range_hit", SB'(rsp_range_hit), SB'(want.hit));
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else if (!finishing) idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic write_csr(input ssm_csr_type idx, input logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_CHUNK_SECTORS: chunk_reg = val[31:0];
         CSR_STRIPE_COUNT:  stripes_reg = val[4:0];
         default:           base_reg = val[SB-1:0];
      endcase
   endtask

   task automatic drain();
      while (expected_maps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] ch, input logic [4:0] ns,
                            input logic [SB-1:0] base);
      drain();
      write_csr(CSR_CHUNK_SECTORS, {16'd0, ch});
      write_csr(CSR_STRIPE_COUNT, {43'd0, ns});
      write_csr(CSR_TARGET_BASE, base);
   endtask

   // one request transfer; start stays high across back-to-back items
   task automatic send_request(input map_op_type op, input logic [SB-1:0] sec,
                               input logic [SB-1:0] esec, input logic [3:0] tgt);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_sector <= sec;
      req_end_sector <= esec;
      req_target_stripe <= tgt;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_maps.push_back(predict_mapping(op, sec, esec, tgt));
      @(negedge clock);
   endtask

   task automatic idle_sender();
      start <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [SB-1:0] rand_sector();
      logic [SB-1:0] s;
      s = SB'({$urandom, $urandom});
      case ($urandom_range(3))
         0: s = s & 48'hFFFF;
         1: s = base_reg + (s & 48'hFFFFF);
         default: ;
      endcase
      return s;
   endfunction

   task automatic test_directed_single();
      configure(32'd8, 5'd4, 48'd100);
      send_request(OP_SINGLE, 48'd100, '0, '0);
      send_request(OP_SINGLE, 48'd0, '0, '0);             // below base, wraps
      send_request(OP_SINGLE, SEC_MAX, SEC_MAX, 4'hF);
      send_request(OP_SINGLE, 48'd133, '0, '0);
      idle_sender();
      configure(32'd0, 5'd0, 48'd0);                      // zero chunk and stripes
      send_request(OP_SINGLE, 48'd77, '0, '0);
      send_request(OP_SINGLE, SEC_MAX, '0, '0);
      idle_sender();
      configure(32'hFFFFFFFF, 5'd31, SEC_MAX);            // saturated stripe count
      send_request(OP_SINGLE, 48'd5, '0, '0);
      send_request(OP_SINGLE, SEC_MAX - 1, '0, '0);
      idle_sender();
   endtask

   task automatic test_directed_range();
      configure(32'd8, 5'd4, 48'd0);
      send_request(OP_RANGE, 48'd0, 48'd64, 4'd0);
      send_request(OP_RANGE, 48'd3, 48'd61, 4'd2);
      send_request(OP_RANGE, 48'd20, 48'd10, 4'd1);       // no overlap
      send_request(OP_RANGE, 48'd0, 48'd64, 4'd7);        // device not present
      send_request(OP_RANGE, 48'd9, 48'd9, 4'd3);
      send_request(OP_RANGE, 48'd0, SEC_MAX, 4'd0);
      idle_sender();
      configure(32'hFFFFFFFF, 5'd16, 48'd0);              // next chunk saturates
      send_request(OP_RANGE, SEC_MAX - 2, SEC_MAX, 4'd0);
      send_request(OP_RANGE, 48'd0, SEC_MAX, 4'd15);
      send_request(OP_RANGE, '0, '0, 4'd15);
      idle_sender();
   endtask

   task automatic random_phase(input int count, input int idle_pct);
      logic [31:0] ch;
      logic [4:0] ns;
      case ($urandom_range(3))
         0: ch = $urandom_range(1, 16);
         1: ch = 32'd1 << $urandom_range(0, 31);
         2: ch = $urandom;
         default: ch = $urandom_range(0, 1000);
      endcase
      ns = ($urandom_range(4) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
      configure(ch, ns, ($urandom_range(1) == 0) ? '0 : SB'({$urandom, $urandom}));
      send_idle_pct = idle_pct;
      for (int i = 0; i < count; i++) begin
         logic [SB-1:0] a, b;
         a = rand_sector();
         b = ($urandom_range(3) == 0) ? rand_sector() : a + $urandom_range(0, 4096);
         send_request(map_op_type'($urandom_range(1)), a, b, 4'($urandom));
         if (i == count / 2 && $urandom_range(1)) begin
            // hold off until every result is back
            idle_sender();
            drain();
         end
      end
      idle_sender();
      send_idle_pct = 0;
   endtask

   task automatic test_random();
      int pcts[4] = '{0, 67, 0, 19};
      for (int p = 0; p < 20; p++)
         random_phase(70, pcts[p % 4]);
   endtask

   initial begin
      chunk_reg = 32'd8;
      stripes_reg = 5'd1;
      base_reg = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_single();
      test_directed_range();
      test_random();
      drain();
      finishing = 1'b1;
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_total == 0 && expected_maps.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
